// File: sv/tlbtu_pkg.sv
// ----------------------------------------------------------------------------
// tlbtu_pkg
// Shared widths, codes and controller/datapath interface types for the
// TLB translate block.
// ----------------------------------------------------------------------------
package tlbtu_pkg;

  localparam int VA_W      = 16;
  localparam int PAGE_W    = 6;
  localparam int OFF_W     = 10;
  localparam int FRAME_W   = 14;
  localparam int PROT_W    = 3;
  localparam int PA_W      = FRAME_W + OFF_W;
  localparam int CFG_W     = 6;
  localparam int APB_DW    = 32;
  localparam int APB_AW    = 3;

  localparam int PAGE_COUNT    = 64;
  localparam int TLB_DEPTH_DEF = 32;

  localparam logic [CFG_W-1:0] CFG_ENTRIES_RST = CFG_W'(32);

  // register index taken from the word address bit
  localparam logic REG_TLB_ENTRIES = 1'b0;

  localparam logic REQ_TRANSLATE = 1'b0;
  localparam logic REQ_WRITE     = 1'b1;

  typedef enum logic [1:0] {
    STS_OK         = 2'd0,
    STS_SEG_FAULT  = 2'd1,
    STS_PROT_FAULT = 2'd2,
    STS_WRITTEN    = 2'd3
  } tlbtu_status_t;

  // controller -> datapath
  typedef struct packed {
    logic capture;   // latch the incoming transaction
    logic exec;      // table write, or tlb lookup plus table read
    logic resolve;   // miss handling with the table entry
    logic load_out;  // move result into the output register
  } tlbtu_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_write;
    logic hit;
  } tlbtu_sts_t;

endpackage

// File: sv/tlbtu_ctrl.sv
// ----------------------------------------------------------------------------
// tlbtu_ctrl
// Sequencer for one transaction at a time plus output valid tracking.
// ----------------------------------------------------------------------------
module tlbtu_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  output logic               out_tvalid,
  input  logic               out_tready,
  input  tlbtu_pkg::tlbtu_sts_t sts,
  output tlbtu_pkg::tlbtu_cmd_t cmd
);
  import tlbtu_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_MISS,
    S_RESP
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free   = !out_valid_r || out_tready;
  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;

  always_comb begin
    state_nxt   = state_r;
    cmd         = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec = 1'b1;
        if (sts.is_write || sts.hit) begin
          state_nxt = S_RESP;
        end else begin
          state_nxt = S_MISS;
        end
      end
      S_MISS: begin
        cmd.resolve = 1'b1;
        state_nxt   = S_RESP;
      end
      S_RESP: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// File: sv/tlbtu_dp.sv
// ----------------------------------------------------------------------------
// tlbtu_dp
// TLB slots in flops with parallel tag compare, page table memory,
// use-bit victim choice and the result/output registers.
// ----------------------------------------------------------------------------
module tlbtu_dp #(
  parameter int TLB_DEPTH = tlbtu_pkg::TLB_DEPTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  tlbtu_pkg::tlbtu_cmd_t            cmd,
  output tlbtu_pkg::tlbtu_sts_t            sts,
  input  logic [tlbtu_pkg::CFG_W-1:0]      cfg_entries,
  input  logic                             req_type,
  input  logic [tlbtu_pkg::VA_W-1:0]       virtual_address,
  input  logic [tlbtu_pkg::PAGE_W-1:0]     entry_page,
  input  logic [tlbtu_pkg::FRAME_W-1:0]    entry_frame,
  input  logic                             entry_valid,
  input  logic [tlbtu_pkg::PROT_W-1:0]     entry_protect,
  output logic [tlbtu_pkg::PA_W-1:0]       phys_addr,
  output tlbtu_pkg::tlbtu_status_t         status,
  output logic                             tlb_hit
);
  import tlbtu_pkg::*;

  localparam int IDX_W   = $clog2(TLB_DEPTH);
  localparam int CNT_W   = CFG_W + 1;
  localparam int PTD_W   = FRAME_W + 1 + PROT_W;
  localparam int PT_AW   = $clog2(PAGE_COUNT);
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(TLB_DEPTH);

  // captured transaction
  logic                  type_r;
  logic [VA_W-1:0]       va_r;
  logic [PAGE_W-1:0]     epage_r;
  logic [FRAME_W-1:0]    eframe_r;
  logic                  evalid_r;
  logic [PROT_W-1:0]     eprot_r;

  // tlb slots
  logic [PAGE_W-1:0]     tag_r   [TLB_DEPTH];
  logic [FRAME_W-1:0]    sframe_r[TLB_DEPTH];
  logic [PROT_W-1:0]     sprot_r [TLB_DEPTH];
  logic [TLB_DEPTH-1:0]  filled_r, filled_nxt;
  logic [TLB_DEPTH-1:0]  use_r, use_nxt;

  // page table
  logic [PTD_W-1:0]      pt_mem [PAGE_COUNT];
  logic [PAGE_COUNT-1:0] pt_wr_r, pt_wr_nxt;
  logic [PTD_W-1:0]      pt_rd_r;
  logic                  pt_rdv_r;

  // result and output registers
  logic [PA_W-1:0]       res_pa_r, res_pa_nxt;
  tlbtu_status_t         res_sts_r, res_sts_nxt;
  logic                  res_hit_r, res_hit_nxt;
  logic [PA_W-1:0]       out_pa_r;
  tlbtu_status_t         out_sts_r;
  logic                  out_hit_r;

  logic [PAGE_W-1:0]     page;
  logic [OFF_W-1:0]      off;
  logic [CNT_W-1:0]      n_act;
  logic [TLB_DEPTH-1:0]  act;
  logic [TLB_DEPTH-1:0]  match;
  logic                  hit_any;
  logic [IDX_W-1:0]      hit_idx;
  logic [TLB_DEPTH-1:0]  free;
  logic                  free_any;
  logic [IDX_W-1:0]      vic_idx;
  logic [PTD_W-1:0]      pt_ent;
  logic [FRAME_W-1:0]    pt_frame;
  logic                  pt_valid;
  logic [PROT_W-1:0]     pt_prot;
  logic                  do_fill;

  assign page = va_r[VA_W-1 -: PAGE_W];
  assign off  = va_r[OFF_W-1:0];

  // slot count: zero acts as one, clamp to depth
  always_comb begin
    if (cfg_entries == '0) begin
      n_act = CNT_W'(1);
    end else if ({1'b0, cfg_entries} > DEPTH_C) begin
      n_act = DEPTH_C;
    end else begin
      n_act = {1'b0, cfg_entries};
    end
  end

  always_comb begin
    for (int i = 0; i < TLB_DEPTH; i++) begin
      act[i]   = CNT_W'(i) < n_act;
      match[i] = act[i] && filled_r[i] && (tag_r[i] == page);
      free[i]  = act[i] && !use_r[i];
    end
  end

  // first matching slot, first slot with clear use bit
  always_comb begin
    hit_idx = '0;
    vic_idx = '0;
    for (int i = TLB_DEPTH - 1; i >= 0; i--) begin
      if (match[i]) begin
        hit_idx = IDX_W'(i);
      end
      if (free[i]) begin
        vic_idx = IDX_W'(i);
      end
    end
  end

  assign hit_any  = |match;
  assign free_any = |free;

  assign sts.is_write = (type_r == REQ_WRITE);
  assign sts.hit      = hit_any;

  // unwritten table entries read as zero
  assign pt_ent   = pt_rdv_r ? pt_rd_r : '0;
  assign pt_frame = pt_ent[PTD_W-1 -: FRAME_W];
  assign pt_valid = pt_ent[PROT_W];
  assign pt_prot  = pt_ent[PROT_W-1:0];
  assign do_fill  = cmd.resolve && pt_valid && (pt_prot != '0);

  always_comb begin
    res_pa_nxt  = res_pa_r;
    res_sts_nxt = res_sts_r;
    res_hit_nxt = res_hit_r;
    use_nxt     = use_r;
    filled_nxt  = filled_r;
    pt_wr_nxt   = pt_wr_r;
    if (cmd.exec) begin
      if (type_r == REQ_WRITE) begin
        pt_wr_nxt[epage_r] = 1'b1;
        res_pa_nxt         = '0;
        res_sts_nxt        = STS_WRITTEN;
        res_hit_nxt        = 1'b0;
      end else if (hit_any) begin
        use_nxt[hit_idx] = 1'b1;
        res_hit_nxt      = 1'b1;
        if (sprot_r[hit_idx] != '0) begin
          res_pa_nxt  = {sframe_r[hit_idx], off};
          res_sts_nxt = STS_OK;
        end else begin
          res_pa_nxt  = '0;
          res_sts_nxt = STS_PROT_FAULT;
        end
      end
    end
    if (cmd.resolve) begin
      res_hit_nxt = 1'b0;
      if (!pt_valid) begin
        res_pa_nxt  = '0;
        res_sts_nxt = STS_SEG_FAULT;
      end else if (pt_prot == '0) begin
        res_pa_nxt  = '0;
        res_sts_nxt = STS_PROT_FAULT;
      end else begin
        // all use bits set: clear the searched ones, slot 0 is the victim
        if (!free_any) begin
          use_nxt = use_r & ~act;
        end
        use_nxt[vic_idx]    = 1'b1;
        filled_nxt[vic_idx] = 1'b1;
        res_pa_nxt          = {pt_frame, off};
        res_sts_nxt         = STS_OK;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      filled_r  <= '0;
      use_r     <= '0;
      pt_wr_r   <= '0;
    end else begin
      filled_r  <= filled_nxt;
      use_r     <= use_nxt;
      pt_wr_r   <= pt_wr_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      type_r   <= req_type;
      va_r     <= virtual_address;
      epage_r  <= entry_page;
      eframe_r <= entry_frame;
      evalid_r <= entry_valid;
      eprot_r  <= entry_protect;
    end
    if (do_fill) begin
      tag_r[vic_idx]    <= page;
      sframe_r[vic_idx] <= pt_frame;
      sprot_r[vic_idx]  <= pt_prot;
    end
    res_pa_r  <= res_pa_nxt;
    res_sts_r <= res_sts_nxt;
    res_hit_r <= res_hit_nxt;
    if (cmd.load_out) begin
      out_pa_r  <= res_pa_r;
      out_sts_r <= res_sts_r;
      out_hit_r <= res_hit_r;
    end
  end

  // page table memory, one write or one registered read per cycle
  always_ff @(posedge clk) begin
    if (cmd.exec && (type_r == REQ_WRITE)) begin
      pt_mem[epage_r[PT_AW-1:0]] <= {eframe_r, evalid_r, eprot_r};
    end
    if (cmd.exec && (type_r == REQ_TRANSLATE)) begin
      pt_rd_r  <= pt_mem[page[PT_AW-1:0]];
      pt_rdv_r <= pt_wr_r[page];
    end
  end

  assign phys_addr = out_pa_r;
  assign status    = out_sts_r;
  assign tlb_hit   = out_hit_r;

endmodule

// File: sv/tlb_translate_use_bit.sv
// ----------------------------------------------------------------------------
// tlb_translate_use_bit
// Virtual to physical address translation through a small TLB with
// clock-style use bits, backed by a page table loaded by write transactions.
// ----------------------------------------------------------------------------
// usage
//   in_*  : stream of requests; tuser selects translate (0) or table write (1)
//   out_* : one result per request: physical address, status, tlb hit flag
//   cfg_* : one register at byte address 0, number of tlb slots in use
//   one request is worked on at a time; the next is taken once the previous
//   result has moved to the output register
//   steps per transaction for a table write or a tlb hit: accept, lookup,
//   result; on a miss a resolve step comes between lookup and result, using
//   the registered page table memory read before the slot fill
//   tags sit in flops and are all compared in the lookup cycle
//   reset: tlb slots empty, use bits clear, page table reads as all zero
//   (per-entry written flags, no clearing pass), slot count 32
//   when the receiver stalls the result waits in the output register; a
//   further result waits in the datapath and input is held off until the
//   output register frees
//   config writes are expected only while the block is idle
// ----------------------------------------------------------------------------
module tlb_translate_use_bit #(
  parameter int TLB_DEPTH = tlbtu_pkg::TLB_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // in_tdata: virtual_address[15:0], entry_page[21:16], entry_frame[35:22],
  //           entry_valid[36], entry_protect[39:37]
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [39:0]                   in_tdata,
  // in_tuser: req_type[0]
  input  logic [0:0]                    in_tuser,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // out_tdata: phys_addr[23:0]
  output logic [23:0]                   out_tdata,
  // out_tuser: status[1:0], tlb_hit[2]
  output logic [2:0]                    out_tuser,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [tlbtu_pkg::APB_AW-1:0]  cfg_paddr,
  input  logic [tlbtu_pkg::APB_DW-1:0]  cfg_pwdata,
  output logic [tlbtu_pkg::APB_DW-1:0]  cfg_prdata,
  output logic                          cfg_pready
);
  import tlbtu_pkg::*;

  tlbtu_cmd_t       cmd;
  tlbtu_sts_t       sts;
  logic [CFG_W-1:0] entries_r;
  logic             reg_sel;
  logic             cfg_wr;
  logic [PA_W-1:0]  pa;
  tlbtu_status_t    res_sts;
  logic             res_hit;

  // config port, zero wait state
  assign cfg_pready = 1'b1;
  assign reg_sel    = cfg_paddr[2];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entries_r <= CFG_ENTRIES_RST;
    end else if (cfg_wr && (reg_sel == REG_TLB_ENTRIES)) begin
      entries_r <= cfg_pwdata[CFG_W-1:0];
    end
  end

  // reads outside the register list return zero
  always_comb begin
    cfg_prdata = '0;
    if (reg_sel == REG_TLB_ENTRIES) begin
      cfg_prdata = APB_DW'(entries_r);
    end
  end

  tlbtu_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  tlbtu_dp #(
    .TLB_DEPTH (TLB_DEPTH)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .cfg_entries      (entries_r),
    .req_type         (in_tuser[0]),
    .virtual_address  (in_tdata[15:0]),
    .entry_page       (in_tdata[21:16]),
    .entry_frame      (in_tdata[35:22]),
    .entry_valid      (in_tdata[36]),
    .entry_protect    (in_tdata[39:37]),
    .phys_addr        (pa),
    .status           (res_sts),
    .tlb_hit          (res_hit)
  );

  assign out_tdata = pa;
  assign out_tuser = {res_hit, res_sts};

endmodule
